@@ rtl/core/point_rotate_about_center_assert.svh @@
// Assertion macros used by the checker of the point rotator.
`ifndef POINT_ROTATE_ABOUT_CENTER_ASSERT_SVH
`define POINT_ROTATE_ABOUT_CENTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRAC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/prac_pkg.sv @@
`timescale 1ns / 1ps

package prac_pkg;

   // Angle field and its reduced form.
   localparam int ANG_BITS   = 17;
   localparam int ANGR_BITS  = 15;
   localparam int DEG_BITS   = 18;

   // CORDIC data path widths: angle in Q30, vector in Q30 with headroom.
   localparam int ATAN_BITS  = 30;
   localparam int Z_BITS     = ATAN_BITS + 3;
   localparam int XY_BITS    = 34;
   localparam int CS_BITS    = 31;
   localparam int FRAC_SHIFT = 28;
   localparam int MAX_STAGES = 24;

   // Angles in units of 1/128 degree.
   localparam logic signed [ANG_BITS:0] FULL_TURN     = 18'sd46080;
   localparam logic signed [ANG_BITS:0] NEG_TURN      = -18'sd46080;
   localparam logic signed [ANG_BITS:0] TWO_TURNS     = 18'sd92160;
   localparam logic signed [ANG_BITS:0] HALF_TURN     = 18'sd23040;
   localparam logic signed [ANG_BITS:0] QUARTER_TURN  = 18'sd11520;
   localparam logic signed [ANG_BITS:0] THREE_QUARTER = 18'sd34560;

   // pi / 23040 in Q30, rounded.
   localparam logic [DEG_BITS-1:0] DEG_TO_Q30 = 18'd146409;

   // Inverse CORDIC gain in Q30, rounded.
   localparam logic signed [XY_BITS-1:0] X_INIT  = 34'sd652032874;
   localparam logic signed [XY_BITS-1:0] RND_Q28 = 34'sd2;

   // atan(2^-idx) in Q30, truncated.
   function automatic logic [ATAN_BITS-1:0] atan_q30(input int unsigned idx);
      logic [ATAN_BITS-1:0] val;
      unique case (idx)
         0:  val = 30'd843314856;
         1:  val = 30'd497837829;
         2:  val = 30'd263043836;
         3:  val = 30'd133525158;
         4:  val = 30'd67021686;
         5:  val = 30'd33543515;
         6:  val = 30'd16775850;
         7:  val = 30'd8388437;
         8:  val = 30'd4194282;
         9:  val = 30'd2097149;
         10: val = 30'd1048575;
         11: val = 30'd524287;
         12: val = 30'd262143;
         13: val = 30'd131071;
         14: val = 30'd65535;
         15: val = 30'd32767;
         16: val = 30'd16383;
         17: val = 30'd8191;
         18: val = 30'd4095;
         19: val = 30'd2047;
         20: val = 30'd1023;
         21: val = 30'd511;
         22: val = 30'd255;
         23: val = 30'd127;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ rtl/core/point_rotate_about_center.sv @@
// Pipeline: stages A and B, one CORDIC stage per iteration (ROT_STAGES capped at 24),
// then stages F, M, S and O. Throughput: one request per cycle while the result is
// not stalled; every stage of the pipeline takes a new request each cycle it may load.
// A stalled result only holds the stages that are full; bubbles are squeezed out.
// Reset (synchronous, active high) clears the valid bits; data path registers have no reset.
`timescale 1ns / 1ps

module point_rotate_about_center
   import prac_pkg::*;
#(
   parameter int ROT_STAGES = 16,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic signed [ANG_BITS-1:0]   req_angle,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [COORD_BITS-1:0] rsp_rot_x,
   output logic signed [COORD_BITS-1:0] rsp_rot_y,
   output logic                         rsp_saturated
);

   localparam int NCOR    = (ROT_STAGES < MAX_STAGES) ? ROT_STAGES : MAX_STAGES;
   localparam int NPIPE   = NCOR + 6;
   localparam int ST_A    = 0;
   localparam int ST_B    = 1;
   localparam int ST_COR0 = 2;
   localparam int ST_F    = NCOR + 2;
   localparam int ST_M    = NCOR + 3;
   localparam int ST_S    = NCOR + 4;
   localparam int ST_O    = NCOR + 5;
   localparam int DW      = COORD_BITS + 1;
   localparam int PW      = DW + CS_BITS;
   localparam int SW      = PW + 1;
   localparam int TW      = SW - FRAC_SHIFT;
   localparam int RW      = TW + 1;

   localparam logic signed [SW-1:0] ROUND_HALF =
      $signed({{(SW-FRAC_SHIFT){1'b0}}, 1'b1, {(FRAC_SHIFT-1){1'b0}}});
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   // ---------------------------------------------------------------------
   // Valid bits and stall chain. A stage holds only when it is full and the
   // stage after it holds.
   // ---------------------------------------------------------------------
   logic [NPIPE-1:0] vld_ff;
   logic [NPIPE-1:0] vld_in;
   logic [NPIPE:0]   hold;
   logic [NPIPE-1:0] ld;
   logic [NPIPE-1:0] up_vld;

   assign hold[NPIPE] = rsp_stall;
   for (genvar k = 0; k < NPIPE; k++) begin : g_hold
      assign hold[k] = vld_ff[k] & hold[k+1];
   end

   assign ld        = ~hold[NPIPE-1:0];
   assign up_vld    = {vld_ff[NPIPE-2:0], req_valid};
   assign vld_in    = hold[NPIPE-1:0] | up_vld;
   assign req_stall = hold[ST_A];
   assign rsp_valid = vld_ff[ST_O];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: reduce the angle to [-90, 90] degrees, note a half-turn flip,
   // and form the offsets from the center.
   // ---------------------------------------------------------------------
   logic signed [ANG_BITS:0]   ang_ext;
   logic signed [ANG_BITS:0]   ang_mod;
   logic signed [ANG_BITS:0]   ang_fold;
   logic signed [ANGR_BITS-1:0] a_rr_in, a_rr_ff;
   logic                        a_flip_in, a_flip_ff;
   logic signed [DW-1:0]        a_dx_in, a_dx_ff;
   logic signed [DW-1:0]        a_dy_in, a_dy_ff;
   logic signed [COORD_BITS-1:0] a_ctx_ff, a_cty_ff;

   always_comb begin
      ang_ext = {req_angle[ANG_BITS-1], req_angle};
      priority if (ang_ext >= FULL_TURN) begin
         ang_mod = ang_ext - FULL_TURN;
      end else if (!ang_ext[ANG_BITS]) begin
         ang_mod = ang_ext;
      end else if (ang_ext >= NEG_TURN) begin
         ang_mod = ang_ext + FULL_TURN;
      end else begin
         ang_mod = ang_ext + TWO_TURNS;
      end

      // Angles in the left half plane rotate by the angle less a half turn and negate.
      priority if (ang_mod >= THREE_QUARTER) begin
         ang_fold  = ang_mod - FULL_TURN;
         a_flip_in = 1'b0;
      end else if (ang_mod > QUARTER_TURN) begin
         ang_fold  = ang_mod - HALF_TURN;
         a_flip_in = 1'b1;
      end else begin
         ang_fold  = ang_mod;
         a_flip_in = 1'b0;
      end
      a_rr_in = ang_fold[ANGR_BITS-1:0];
   end

   assign a_dx_in = $signed({req_point_x[COORD_BITS-1], req_point_x})
                  - $signed({req_center_x[COORD_BITS-1], req_center_x});
   assign a_dy_in = $signed({req_point_y[COORD_BITS-1], req_point_y})
                  - $signed({req_center_y[COORD_BITS-1], req_center_y});

   always_ff @(posedge clock) begin
      if (ld[ST_A]) begin
         a_rr_ff   <= a_rr_in;
         a_flip_ff <= a_flip_in;
         a_dx_ff   <= a_dx_in;
         a_dy_ff   <= a_dy_in;
         a_ctx_ff  <= req_center_x;
         a_cty_ff  <= req_center_y;
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: angle to radians in Q30.
   // ---------------------------------------------------------------------
   logic signed [ANGR_BITS+DEG_BITS:0] b_z_prod;
   logic signed [Z_BITS-1:0]           b_z_in, b_z_ff;
   logic                               b_flip_ff;
   logic signed [DW-1:0]               b_dx_ff, b_dy_ff;
   logic signed [COORD_BITS-1:0]       b_ctx_ff, b_cty_ff;

   assign b_z_prod = a_rr_ff * $signed({1'b0, DEG_TO_Q30});
   assign b_z_in   = b_z_prod[Z_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ld[ST_B]) begin
         b_z_ff    <= b_z_in;
         b_flip_ff <= a_flip_ff;
         b_dx_ff   <= a_dx_ff;
         b_dy_ff   <= a_dy_ff;
         b_ctx_ff  <= a_ctx_ff;
         b_cty_ff  <= a_cty_ff;
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC in rotation mode, one register stage per iteration.
   // ---------------------------------------------------------------------
   logic signed [XY_BITS-1:0]    cor_x_src [NCOR];
   logic signed [XY_BITS-1:0]    cor_y_src [NCOR];
   logic signed [Z_BITS-1:0]     cor_z_src [NCOR];
   logic                         cor_flip_src [NCOR];
   logic signed [DW-1:0]         cor_dx_src [NCOR];
   logic signed [DW-1:0]         cor_dy_src [NCOR];
   logic signed [COORD_BITS-1:0] cor_ctx_src [NCOR];
   logic signed [COORD_BITS-1:0] cor_cty_src [NCOR];

   logic signed [XY_BITS-1:0]    cor_x_in [NCOR];
   logic signed [XY_BITS-1:0]    cor_y_in [NCOR];
   logic signed [Z_BITS-1:0]     cor_z_in [NCOR];

   logic signed [XY_BITS-1:0]    cor_x_ff [NCOR];
   logic signed [XY_BITS-1:0]    cor_y_ff [NCOR];
   logic signed [Z_BITS-1:0]     cor_z_ff [NCOR];
   logic                         cor_flip_ff [NCOR];
   logic signed [DW-1:0]         cor_dx_ff [NCOR];
   logic signed [DW-1:0]         cor_dy_ff [NCOR];
   logic signed [COORD_BITS-1:0] cor_ctx_ff [NCOR];
   logic signed [COORD_BITS-1:0] cor_cty_ff [NCOR];

   for (genvar i = 0; i < NCOR; i++) begin : g_cor
      localparam logic signed [Z_BITS-1:0] ATAN_I =
         $signed({{(Z_BITS-ATAN_BITS){1'b0}}, atan_q30(i)});

      if (i == 0) begin : g_first
         assign cor_x_src[i]    = X_INIT;
         assign cor_y_src[i]    = '0;
         assign cor_z_src[i]    = b_z_ff;
         assign cor_flip_src[i] = b_flip_ff;
         assign cor_dx_src[i]   = b_dx_ff;
         assign cor_dy_src[i]   = b_dy_ff;
         assign cor_ctx_src[i]  = b_ctx_ff;
         assign cor_cty_src[i]  = b_cty_ff;
      end else begin : g_next
         assign cor_x_src[i]    = cor_x_ff[i-1];
         assign cor_y_src[i]    = cor_y_ff[i-1];
         assign cor_z_src[i]    = cor_z_ff[i-1];
         assign cor_flip_src[i] = cor_flip_ff[i-1];
         assign cor_dx_src[i]   = cor_dx_ff[i-1];
         assign cor_dy_src[i]   = cor_dy_ff[i-1];
         assign cor_ctx_src[i]  = cor_ctx_ff[i-1];
         assign cor_cty_src[i]  = cor_cty_ff[i-1];
      end

      // A negative residual angle turns the vector clockwise.
      assign cor_x_in[i] = cor_z_src[i][Z_BITS-1] ? cor_x_src[i] + (cor_y_src[i] >>> i)
                                                  : cor_x_src[i] - (cor_y_src[i] >>> i);
      assign cor_y_in[i] = cor_z_src[i][Z_BITS-1] ? cor_y_src[i] - (cor_x_src[i] >>> i)
                                                  : cor_y_src[i] + (cor_x_src[i] >>> i);
      assign cor_z_in[i] = cor_z_src[i][Z_BITS-1] ? cor_z_src[i] + ATAN_I
                                                  : cor_z_src[i] - ATAN_I;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NCOR; i++) begin
         if (ld[ST_COR0+i]) begin
            cor_x_ff[i]    <= cor_x_in[i];
            cor_y_ff[i]    <= cor_y_in[i];
            cor_z_ff[i]    <= cor_z_in[i];
            cor_flip_ff[i] <= cor_flip_src[i];
            cor_dx_ff[i]   <= cor_dx_src[i];
            cor_dy_ff[i]   <= cor_dy_src[i];
            cor_ctx_ff[i]  <= cor_ctx_src[i];
            cor_cty_ff[i]  <= cor_cty_src[i];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage F: undo the half-turn fold and round cosine and sine to Q28.
   // ---------------------------------------------------------------------
   logic signed [XY_BITS-1:0]    f_xn, f_yn, f_xr, f_yr;
   logic signed [CS_BITS-1:0]    f_c_in, f_c_ff;
   logic signed [CS_BITS-1:0]    f_s_in, f_s_ff;
   logic signed [DW-1:0]         f_dx_ff, f_dy_ff;
   logic signed [COORD_BITS-1:0] f_ctx_ff, f_cty_ff;

   assign f_xn   = cor_flip_ff[NCOR-1] ? -cor_x_ff[NCOR-1] : cor_x_ff[NCOR-1];
   assign f_yn   = cor_flip_ff[NCOR-1] ? -cor_y_ff[NCOR-1] : cor_y_ff[NCOR-1];
   assign f_xr   = (f_xn + RND_Q28) >>> 2;
   assign f_yr   = (f_yn + RND_Q28) >>> 2;
   assign f_c_in = f_xr[CS_BITS-1:0];
   assign f_s_in = f_yr[CS_BITS-1:0];

   always_ff @(posedge clock) begin
      if (ld[ST_F]) begin
         f_c_ff   <= f_c_in;
         f_s_ff   <= f_s_in;
         f_dx_ff  <= cor_dx_ff[NCOR-1];
         f_dy_ff  <= cor_dy_ff[NCOR-1];
         f_ctx_ff <= cor_ctx_ff[NCOR-1];
         f_cty_ff <= cor_cty_ff[NCOR-1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage M: the four products of the rotation matrix.
   // ---------------------------------------------------------------------
   logic signed [PW-1:0]         m_dxc_in, m_dxc_ff;
   logic signed [PW-1:0]         m_dys_in, m_dys_ff;
   logic signed [PW-1:0]         m_dxs_in, m_dxs_ff;
   logic signed [PW-1:0]         m_dyc_in, m_dyc_ff;
   logic signed [COORD_BITS-1:0] m_ctx_ff, m_cty_ff;

   assign m_dxc_in = f_dx_ff * f_c_ff;
   assign m_dys_in = f_dy_ff * f_s_ff;
   assign m_dxs_in = f_dx_ff * f_s_ff;
   assign m_dyc_in = f_dy_ff * f_c_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_M]) begin
         m_dxc_ff <= m_dxc_in;
         m_dys_ff <= m_dys_in;
         m_dxs_ff <= m_dxs_in;
         m_dyc_ff <= m_dyc_in;
         m_ctx_ff <= f_ctx_ff;
         m_cty_ff <= f_cty_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage S: combine, round half up and drop the Q28 fraction.
   // ---------------------------------------------------------------------
   logic signed [SW-1:0]         s_sum_x, s_sum_y;
   logic signed [TW-1:0]         s_tx_in, s_tx_ff;
   logic signed [TW-1:0]         s_ty_in, s_ty_ff;
   logic signed [COORD_BITS-1:0] s_ctx_ff, s_cty_ff;

   assign s_sum_x = $signed({m_dxc_ff[PW-1], m_dxc_ff})
                  - $signed({m_dys_ff[PW-1], m_dys_ff}) + ROUND_HALF;
   assign s_sum_y = $signed({m_dxs_ff[PW-1], m_dxs_ff})
                  + $signed({m_dyc_ff[PW-1], m_dyc_ff}) + ROUND_HALF;
   assign s_tx_in = s_sum_x[SW-1:FRAC_SHIFT];
   assign s_ty_in = s_sum_y[SW-1:FRAC_SHIFT];

   always_ff @(posedge clock) begin
      if (ld[ST_S]) begin
         s_tx_ff  <= s_tx_in;
         s_ty_ff  <= s_ty_in;
         s_ctx_ff <= m_ctx_ff;
         s_cty_ff <= m_cty_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage O: add the center back and clip to the coordinate range.
   // ---------------------------------------------------------------------
   logic signed [RW-1:0]         o_rx, o_ry;
   logic                         o_fit_x, o_fit_y;
   logic signed [COORD_BITS-1:0] o_rot_x_in, o_rot_y_in;
   logic                         o_sat_in;
   logic signed [COORD_BITS-1:0] o_rot_x_ff, o_rot_y_ff;
   logic                         o_sat_ff;

   assign o_rx = $signed({{(RW-COORD_BITS){s_ctx_ff[COORD_BITS-1]}}, s_ctx_ff})
               + $signed({{(RW-TW){s_tx_ff[TW-1]}}, s_tx_ff});
   assign o_ry = $signed({{(RW-COORD_BITS){s_cty_ff[COORD_BITS-1]}}, s_cty_ff})
               + $signed({{(RW-TW){s_ty_ff[TW-1]}}, s_ty_ff});

   // The value fits when all bits from the coordinate's sign bit upward agree.
   assign o_fit_x = (&o_rx[RW-1:COORD_BITS-1]) | ~(|o_rx[RW-1:COORD_BITS-1]);
   assign o_fit_y = (&o_ry[RW-1:COORD_BITS-1]) | ~(|o_ry[RW-1:COORD_BITS-1]);

   assign o_rot_x_in = o_fit_x ? o_rx[COORD_BITS-1:0]
                               : (o_rx[RW-1] ? COORD_MIN : COORD_MAX);
   assign o_rot_y_in = o_fit_y ? o_ry[COORD_BITS-1:0]
                               : (o_ry[RW-1] ? COORD_MIN : COORD_MAX);
   assign o_sat_in   = ~o_fit_x | ~o_fit_y;

   always_ff @(posedge clock) begin
      if (ld[ST_O]) begin
         o_rot_x_ff <= o_rot_x_in;
         o_rot_y_ff <= o_rot_y_in;
         o_sat_ff   <= o_sat_in;
      end
   end

   assign rsp_rot_x     = o_rot_x_ff;
   assign rsp_rot_y     = o_rot_y_ff;
   assign rsp_saturated = o_sat_ff;

endmodule

@@ rtl/core/prac_checker.sv @@
`timescale 1ns / 1ps
`include "point_rotate_about_center_assert.svh"

module prac_checker
   import prac_pkg::*;
#(
   parameter int COORD_BITS = 24
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic signed [COORD_BITS-1:0] req_point_x,
   input logic signed [ANG_BITS-1:0]   req_angle,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic signed [COORD_BITS-1:0] rsp_rot_x,
   input logic signed [COORD_BITS-1:0] rsp_rot_y,
   input logic                         rsp_saturated
);

   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic req_seen;
   logic sat_at_bound;

   assign req_seen     = req_valid | (|req_point_x) | (|req_angle) | 1'b1;
   assign sat_at_bound = (rsp_rot_x == COORD_MAX) || (rsp_rot_x == COORD_MIN)
                      || (rsp_rot_y == COORD_MAX) || (rsp_rot_y == COORD_MIN);

   // The request side only stalls when every stage is full and the result is stalled.
   `PRAC_ASSERT_SAME(a_stall_only_when_full, clock, reset, req_stall && req_seen, rsp_valid && rsp_stall, "request stalled while the result side is free")

   // A clipped result must sit on a bound of the coordinate range.
   `PRAC_ASSERT_SAME(a_sat_at_bound, clock, reset, rsp_valid && rsp_saturated, sat_at_bound, "saturated result is not at a range bound")

   // Reset empties the pipeline.
   `PRAC_ASSERT_SAME(a_reset_empties, clock, 1'b0, $past(reset), !rsp_valid, "result valid right after reset")

   // A stalled result keeps its value.
   `PRAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_rot_x) && $stable(rsp_rot_y) && $stable(rsp_saturated), "stalled result changed")

endmodule

bind point_rotate_about_center prac_checker #(
   .COORD_BITS(COORD_BITS)
) u_prac_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_point_x  (req_point_x),
   .req_angle    (req_angle),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_rot_x    (rsp_rot_x),
   .rsp_rot_y    (rsp_rot_y),
   .rsp_saturated(rsp_saturated)
);

@@ test/point_rotate_about_center_checker.sv @@
`timescale 1ns / 1ps

module point_rotate_about_center_checker
   import prac_pkg::*;
#(
   parameter int ROT_STAGES = 16,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic signed [ANG_BITS-1:0]   req_angle,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [COORD_BITS-1:0] rsp_rot_x,
   input  logic signed [COORD_BITS-1:0] rsp_rot_y,
   input  logic                         rsp_saturated,
   output int                           mismatches,
   output int                           outstanding
);

   typedef struct {
      logic signed [COORD_BITS-1:0] rot_x;
      logic signed [COORD_BITS-1:0] rot_y;
      logic                         saturated;
   } rotation_type;

   localparam longint ARCTAN_Q30 [0:MAX_STAGES-1] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127
   };
   localparam longint HALF_LSB_Q28 = longint'(1) << 27;
   localparam longint COORD_HI     = (longint'(1) << (COORD_BITS - 1)) - 1;
   localparam longint COORD_LO     = -COORD_HI - 1;

   rotation_type expected_rotations[$];
   rotation_type want;
   int           mismatch_count = 0;
   int           pending_count  = 0;

   assign mismatches  = mismatch_count;
   assign outstanding = pending_count;

   function automatic rotation_type rotate_point(
      input logic signed [COORD_BITS-1:0] px,
      input logic signed [COORD_BITS-1:0] py,
      input logic signed [COORD_BITS-1:0] cx,
      input logic signed [COORD_BITS-1:0] cy,
      input logic signed [ANG_BITS-1:0]   ang
   );
      longint       r, x, y, z, xs, ys, c, s, dx, dy, rx, ry;
      bit           flip, sat;
      rotation_type res;
      flip = 1'b0;
      sat  = 1'b0;
      r = longint'(ang) % longint'(FULL_TURN);
      if (r < 0) r += longint'(FULL_TURN);
      // Fold the angle into [-90, 90] degrees; the far half negates sin and cos.
      if (r >= longint'(THREE_QUARTER)) begin
         r -= longint'(FULL_TURN);
      end else if (r > longint'(QUARTER_TURN)) begin
         r -= longint'(HALF_TURN);
         flip = 1'b1;
      end
      z = r * longint'(DEG_TO_Q30);
      x = longint'(X_INIT);
      y = 0;
      for (int i = 0; i < ROT_STAGES && i < MAX_STAGES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ARCTAN_Q30[i];
         end else begin
            x += ys;
            y -= xs;
            z += ARCTAN_Q30[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c  = (x + 2) >>> 2;
      s  = (y + 2) >>> 2;
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      rx = longint'(cx) + ((dx * c - dy * s + HALF_LSB_Q28) >>> 28);
      ry = longint'(cy) + ((dx * s + dy * c + HALF_LSB_Q28) >>> 28);
      if (rx > COORD_HI) begin rx = COORD_HI; sat = 1'b1; end
      if (rx < COORD_LO) begin rx = COORD_LO; sat = 1'b1; end
      if (ry > COORD_HI) begin ry = COORD_HI; sat = 1'b1; end
      if (ry < COORD_LO) begin ry = COORD_LO; sat = 1'b1; end
      res.rot_x     = COORD_BITS'(rx);
      res.rot_y     = COORD_BITS'(ry);
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_rotations.delete();
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rotations.push_back(rotate_point(req_point_x, req_point_y,
                                                      req_center_x, req_center_y,
                                                      req_angle));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rotations.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual x=%0d y=%0d sat=%0d",
                        $time, rsp_rot_x, rsp_rot_y, rsp_saturated);
               mismatch_count++;
            end else begin
               want = expected_rotations.pop_front();
               if (rsp_rot_x !== want.rot_x) begin
                  $display("%0t: rot_x mismatch, expected %0d, actual %0d",
                           $time, want.rot_x, rsp_rot_x);
                  mismatch_count++;
               end
               if (rsp_rot_y !== want.rot_y) begin
                  $display("%0t: rot_y mismatch, expected %0d, actual %0d",
                           $time, want.rot_y, rsp_rot_y);
                  mismatch_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated mismatch, expected %0d, actual %0d",
                           $time, want.saturated, rsp_saturated);
                  mismatch_count++;
               end
            end
         end
         pending_count <= expected_rotations.size();
      end
   end

endmodule

@@ test/point_rotate_about_center_tb.sv @@
`timescale 1ns / 1ps

module point_rotate_about_center_tb;
   import prac_pkg::*;

   localparam int ROT_STAGES     = 16;
   localparam int COORD_BITS     = 24;
   localparam int LATENCY        = ROT_STAGES + 6;
   localparam int RANDOM_POINTS  = 1900;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic signed [COORD_BITS-1:0] req_point_x = '0;
   logic signed [COORD_BITS-1:0] req_point_y = '0;
   logic signed [COORD_BITS-1:0] req_center_x = '0;
   logic signed [COORD_BITS-1:0] req_center_y = '0;
   logic signed [ANG_BITS-1:0]   req_angle = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [COORD_BITS-1:0] rsp_rot_x;
   logic signed [COORD_BITS-1:0] rsp_rot_y;
   logic                         rsp_saturated;

   int mismatches;
   int outstanding;
   int idle_cycles = 0;
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   point_rotate_about_center #(
      .ROT_STAGES(ROT_STAGES),
      .COORD_BITS(COORD_BITS)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_angle    (req_angle),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rot_x    (rsp_rot_x),
      .rsp_rot_y    (rsp_rot_y),
      .rsp_saturated(rsp_saturated)
   );

   point_rotate_about_center_checker #(
      .ROT_STAGES(ROT_STAGES),
      .COORD_BITS(COORD_BITS)
   ) i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_angle    (req_angle),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_rot_x    (rsp_rot_x),
      .rsp_rot_y    (rsp_rot_y),
      .rsp_saturated(rsp_saturated),
      .mismatches   (mismatches),
      .outstanding  (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Result side: a random stall before each result, in phases with and without stalls.
   initial begin : result_sink
      int hold;
      int taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken % 100 == 0) receiver_idles = ($urandom_range(0, 3) != 0);
         hold = receiver_idles ? $urandom_range(0, 6) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   task automatic send_request(input int px, input int py, input int cx, input int cy,
                               input int ang);
      int gap;
      gap = sender_idles ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_point_x  <= COORD_BITS'(px);
      req_point_y  <= COORD_BITS'(py);
      req_center_x <= COORD_BITS'(cx);
      req_center_y <= COORD_BITS'(cy);
      req_angle    <= ANG_BITS'(ang);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off new requests until every outstanding result has come back.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic int random_coord();
      logic signed [COORD_BITS-1:0] full;
      int pick;
      pick = $urandom_range(0, 19);
      full = COORD_BITS'($urandom);
      if (pick < 10) return int'($urandom_range(0, 131071)) - 65536;
      if (pick < 17) return int'(full);
      if (pick == 17) return COORD_MAX - int'($urandom_range(0, 255));
      return COORD_MIN + int'($urandom_range(0, 255));
   endfunction

   function automatic int random_angle();
      logic signed [ANG_BITS-1:0] raw;
      int pick;
      pick = $urandom_range(0, 9);
      raw  = ANG_BITS'($urandom);
      if (pick < 6) return int'($urandom_range(0, 92160)) - int'(FULL_TURN);
      if (pick < 8) return int'(raw);
      return (int'($urandom_range(0, 8)) - 4) * int'(QUARTER_TURN)
             + int'($urandom_range(0, 4)) - 2;
   endfunction

   initial begin : stimulus
      int qt;
      int ht;
      int ft;
      qt = int'(QUARTER_TURN);
      ht = int'(HALF_TURN);
      ft = int'(FULL_TURN);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Quadrant boundaries, full turns and the ends of the angle field.
      send_request(0, 0, 0, 0, 0);
      send_request(256, 0, 0, 0, 0);
      send_request(256, 0, 0, 0, qt);
      send_request(256, 512, 0, 0, qt + 1);
      send_request(256, 512, 0, 0, ht);
      send_request(256, 512, 0, 0, int'(THREE_QUARTER) - 1);
      send_request(256, 512, 0, 0, int'(THREE_QUARTER));
      send_request(1000, -700, 300, 200, ft);
      send_request(1000, -700, 300, 200, -ft);
      send_request(1000, -700, 300, 200, -1);
      send_request(1000, -700, 300, 200, 1);
      send_request(1000, -700, 300, 200, (1 << (ANG_BITS - 1)) - 1);
      send_request(1000, -700, 300, 200, -(1 << (ANG_BITS - 1)));
      // Coordinate extremes, with clipping on each side.
      send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 0);
      send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, ht);
      send_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, ht);
      send_request(COORD_MAX, 0, 0, 0, qt / 2);
      send_request(COORD_MIN, COORD_MIN, 0, 0, qt / 2);
      send_request(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 12345);
      send_request(-5000, 7000, -5000, 7000, 777);
      send_request(COORD_MIN, COORD_MAX, 0, 0, -qt);
      drain_pipeline();

      for (int n = 0; n < RANDOM_POINTS; n++) begin
         if (n % 100 == 0) sender_idles = ($urandom_range(0, 3) != 0);
         if (n % 600 == 300) drain_pipeline();
         send_request(random_coord(), random_coord(), random_coord(), random_coord(),
                      random_angle());
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/prac_pkg.sv
rtl/core/point_rotate_about_center.sv
rtl/core/prac_checker.sv
test/point_rotate_about_center_checker.sv
test/point_rotate_about_center_tb.sv
